FILE: rtl/crts_pkg.sv
// ----------------------------------------------------------------------------
// crts_pkg
// Shared types and constants for the circle ring tile scan block.
// ----------------------------------------------------------------------------
package crts_pkg;

    // Default build parameters
    localparam int MAX_GRID_SIDE_DEF = 1024;
    localparam int MAX_RADIUS_DEF    = 10;

    // Field widths
    localparam int POS_W      = 24;
    localparam int UNIT_W     = 16;
    localparam int GRID_W     = 11;
    localparam int RADIUS_W   = 4;
    localparam int OFF_W      = 5;
    localparam int IDX_W      = 20;
    localparam int CFG_IDX_W  = 3;
    localparam int CFG_DATA_W = 24;
    localparam int S_TDATA_W  = 56;
    localparam int M_TDATA_W  = 32;

    // Divider geometry: |pos - origin| always fits POS_W bits
    localparam int DIVIDEND_W = POS_W;
    localparam int DIVISOR_W  = UNIT_W;
    localparam int DIV_CNT_W  = $clog2(DIVIDEND_W);
    localparam int CENTRE_W   = POS_W + 1;
    localparam int COORD_W    = CENTRE_W + 1;

    // At most 64 points, eight per walk step
    localparam int STEP_W     = 3;

    // Configuration register indexes
    localparam logic [CFG_IDX_W-1:0] REG_ORIGIN_X    = 3'd0;
    localparam logic [CFG_IDX_W-1:0] REG_ORIGIN_Z    = 3'd1;
    localparam logic [CFG_IDX_W-1:0] REG_TILE_UNIT   = 3'd2;
    localparam logic [CFG_IDX_W-1:0] REG_GRID_WIDTH  = 3'd3;
    localparam logic [CFG_IDX_W-1:0] REG_GRID_HEIGHT = 3'd4;

    typedef enum logic [2:0] {
        S_IDLE,
        S_DIV_X,
        S_DIV_Z,
        S_BASE,
        S_EMIT
    } state_t;

    typedef struct packed {
        logic                  start;
        logic [DIVIDEND_W-1:0] dividend;
        logic [DIVISOR_W-1:0]  divisor;
    } div_req_t;

    typedef struct packed {
        logic                  done;
        logic [DIVIDEND_W-1:0] quotient;
    } div_rsp_t;

endpackage

FILE: rtl/circle_ring_tile_scan.sv
// ----------------------------------------------------------------------------
// circle_ring_tile_scan
// Maps a world position onto the tile grid and lists one midpoint circle
// ring of tiles round the centre tile, eight symmetric points per step.
// ----------------------------------------------------------------------------
//  channel  dir  handshake            payload
//  s_       in   s_tvalid/s_tready    tdata: pos_x, pos_z, radius
//  m_       out  m_tvalid/m_tready    tdata: offset_x, offset_z, tile_index
//                                     tuser: in_grid, tlast: last
//  cfg_     in   cfg_wr_en            cfg_wr_index, cfg_wr_data
//
//  One request runs the x and z divides and a centre-tile base step, then emits one
//  point per cycle unless the output stalls, 8 per walk step, at most 64 points.
//  The bit-serial divider, shared by both axes, sets the set-up time.
//  s_tready is high only between requests; a zero radius returns at once.
//  Output stalls hold the point register and pause the walk.
//  Reset is synchronous, active low, and restores the register defaults.
// ----------------------------------------------------------------------------
module circle_ring_tile_scan #(
    parameter int MAX_GRID_SIDE = crts_pkg::MAX_GRID_SIDE_DEF,
    parameter int MAX_RADIUS    = crts_pkg::MAX_RADIUS_DEF
) (
    input  logic                            aclk,
    input  logic                            aresetn,
    // pos_x [23:0], pos_z [47:24], radius [51:48], zero fill
    input  logic [crts_pkg::S_TDATA_W-1:0]  s_tdata,
    input  logic                            s_tvalid,
    output logic                            s_tready,
    // offset_x [4:0], offset_z [9:5], tile_index [29:10], zero fill
    output logic [crts_pkg::M_TDATA_W-1:0]  m_tdata,
    // in_grid [0]
    output logic                            m_tuser,
    output logic                            m_tlast,
    output logic                            m_tvalid,
    input  logic                            m_tready,
    input  logic                            cfg_wr_en,
    input  logic [crts_pkg::CFG_IDX_W-1:0]  cfg_wr_index,
    input  logic [crts_pkg::CFG_DATA_W-1:0] cfg_wr_data
);
    import crts_pkg::*;

    localparam int SIDE_W = $clog2(MAX_GRID_SIDE + 1);
    localparam int CMP_W  = (SIDE_W > GRID_W) ? SIDE_W : GRID_W;
    localparam int RAD_W  = $clog2(MAX_RADIUS + 1);
    localparam int WALK_W = RAD_W + 1;
    localparam int D_W    = WALK_W + 4;

    // Configuration registers
    logic signed [POS_W-1:0] origin_x_reg, origin_z_reg;
    logic [UNIT_W-1:0]       tile_unit_reg;
    logic [GRID_W-1:0]       grid_width_reg, grid_height_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            origin_x_reg    <= '0;
            origin_z_reg    <= '0;
            tile_unit_reg   <= UNIT_W'(1);
            grid_width_reg  <= GRID_W'(1024);
            grid_height_reg <= GRID_W'(1024);
        end else if (cfg_wr_en) begin
            case (cfg_wr_index)
                REG_ORIGIN_X:    origin_x_reg    <= cfg_wr_data[POS_W-1:0];
                REG_ORIGIN_Z:    origin_z_reg    <= cfg_wr_data[POS_W-1:0];
                REG_TILE_UNIT:   tile_unit_reg   <= cfg_wr_data[UNIT_W-1:0];
                REG_GRID_WIDTH:  grid_width_reg  <= cfg_wr_data[GRID_W-1:0];
                REG_GRID_HEIGHT: grid_height_reg <= cfg_wr_data[GRID_W-1:0];
                default: ;
            endcase
        end
    end

    // Saturated grid sides and guarded tile unit
    logic [CMP_W-1:0]     w_ext, h_ext, w_sat, h_sat;
    logic [DIVISOR_W-1:0] unit_eff;

    assign w_ext    = CMP_W'(grid_width_reg);
    assign h_ext    = CMP_W'(grid_height_reg);
    assign w_sat    = (w_ext > CMP_W'(MAX_GRID_SIDE)) ? CMP_W'(MAX_GRID_SIDE) : w_ext;
    assign h_sat    = (h_ext > CMP_W'(MAX_GRID_SIDE)) ? CMP_W'(MAX_GRID_SIDE) : h_ext;
    assign unit_eff = (tile_unit_reg == '0) ? DIVISOR_W'(1) : tile_unit_reg;

    // Input fields and relative position magnitudes
    logic signed [POS_W-1:0] in_pos_x, in_pos_z;
    logic [RADIUS_W-1:0]     in_radius, radius_sat;
    logic signed [POS_W:0]   diff_x, diff_z, neg_diff_x, neg_diff_z;
    logic [DIVIDEND_W-1:0]   mag_x, mag_z;

    assign in_pos_x   = s_tdata[23:0];
    assign in_pos_z   = s_tdata[47:24];
    assign in_radius  = s_tdata[51:48];
    assign radius_sat = (in_radius > RADIUS_W'(MAX_RADIUS)) ? RADIUS_W'(MAX_RADIUS)
                                                          : in_radius;
    assign diff_x     = (POS_W+1)'(in_pos_x) - (POS_W+1)'(origin_x_reg);
    assign diff_z     = (POS_W+1)'(in_pos_z) - (POS_W+1)'(origin_z_reg);
    assign neg_diff_x = -diff_x;
    assign neg_diff_z = -diff_z;
    assign mag_x      = diff_x[POS_W] ? neg_diff_x[DIVIDEND_W-1:0] : diff_x[DIVIDEND_W-1:0];
    assign mag_z      = diff_z[POS_W] ? neg_diff_z[DIVIDEND_W-1:0] : diff_z[DIVIDEND_W-1:0];

    // Sequencer and walk state
    state_t                   state_reg, state_next;
    logic                     neg_x_reg, neg_z_reg;
    logic [DIVIDEND_W-1:0]    mag_z_reg;
    logic signed [CENTRE_W-1:0] cx_reg, cz_reg, quo_signed;
    logic [IDX_W-1:0]         base_reg;
    logic [WALK_W-1:0]        tx_reg, tz_reg;
    logic signed [D_W-1:0]    d_reg;
    logic [STEP_W-1:0]        step_reg;
    logic [2:0]               pt_reg;

    logic     s_accept, start_walk, load, last_pt;
    div_req_t div_req;
    div_rsp_t div_rsp;

    crts_div u_div (
        .aclk    (aclk),
        .aresetn (aresetn),
        .req     (div_req),
        .rsp     (div_rsp)
    );

    assign s_accept   = s_tvalid && s_tready;
    assign start_walk = s_accept && (radius_sat != '0);
    assign quo_signed = CENTRE_W'(div_rsp.quotient);

    // Walk step arithmetic, applied after the eighth point of a step
    logic [WALK_W-1:0]     tx_step, tz_step;
    logic signed [D_W-1:0] d_step;
    logic                  walk_more;

    always_comb begin
        tx_step = tx_reg + 1'b1;
        if (d_reg < 0) begin
            d_step  = d_reg + (D_W'(tx_reg) <<< 2) + D_W'(6);
            tz_step = tz_reg;
        end else begin
            d_step  = d_reg + ((D_W'(tx_reg) - D_W'(tz_reg)) <<< 2) + D_W'(10);
            tz_step = tz_reg - 1'b1;
        end
        walk_more = (tx_step <= tz_step) && (step_reg != '1);
    end

    // Point of the current step: swap on the upper four, signs from low bits
    logic [WALK_W-1:0]        ax, az;
    logic signed [OFF_W-1:0]  mag_ox, mag_oz, off_x, off_z;
    logic [COORD_W-1:0]       x_coord, z_coord;
    logic                     in_grid;
    logic [IDX_W-1:0]         ozw, tile_idx;

    always_comb begin
        ax      = pt_reg[2] ? tz_reg : tx_reg;
        az      = pt_reg[2] ? tx_reg : tz_reg;
        mag_ox  = OFF_W'(ax);
        mag_oz  = OFF_W'(az);
        off_x   = pt_reg[0] ? -mag_ox : mag_ox;
        off_z   = pt_reg[1] ? -mag_oz : mag_oz;
        x_coord = COORD_W'(cx_reg) + COORD_W'(off_x);
        z_coord = COORD_W'(cz_reg) + COORD_W'(off_z);
        in_grid = !x_coord[COORD_W-1] && !z_coord[COORD_W-1]
               && (x_coord < COORD_W'(w_sat)) && (z_coord < COORD_W'(h_sat));
        ozw      = IDX_W'(IDX_W'(mag_oz) * IDX_W'(w_sat));
        tile_idx = base_reg + IDX_W'(off_x) + (pt_reg[1] ? -ozw : ozw);
        last_pt  = (pt_reg == 3'd7) && !walk_more;
    end

    // Next state
    always_comb begin
        state_next = state_reg;
        case (state_reg)
            S_IDLE:  if (start_walk) state_next = S_DIV_X;
            S_DIV_X: if (div_rsp.done) state_next = S_DIV_Z;
            S_DIV_Z: if (div_rsp.done) state_next = S_BASE;
            S_BASE:  state_next = S_EMIT;
            S_EMIT:  if (load && last_pt) state_next = S_IDLE;
            default: state_next = S_IDLE;
        endcase
    end

    // Control outputs
    always_comb begin
        s_tready         = 1'b0;
        load             = 1'b0;
        div_req.start    = 1'b0;
        div_req.dividend = mag_x;
        div_req.divisor  = unit_eff;
        case (state_reg)
            S_IDLE: begin
                s_tready      = 1'b1;
                div_req.start = start_walk;
            end
            S_DIV_X: begin
                div_req.start    = div_rsp.done;
                div_req.dividend = mag_z_reg;
            end
            S_EMIT: load = !m_tvalid || m_tready;
            default: ;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= S_IDLE;
        end else begin
            state_reg <= state_next;
        end
    end

    // Request capture, centre tile and walk registers
    always_ff @(posedge aclk) begin
        if (s_accept) begin
            neg_x_reg <= diff_x[POS_W];
            neg_z_reg <= diff_z[POS_W];
            mag_z_reg <= mag_z;
            tx_reg    <= '0;
            tz_reg    <= WALK_W'(radius_sat);
            d_reg     <= D_W'(3) - (D_W'(radius_sat) <<< 1);
            step_reg  <= '0;
            pt_reg    <= '0;
        end
        if (state_reg == S_DIV_X && div_rsp.done) begin
            cx_reg <= neg_x_reg ? -quo_signed : quo_signed;
        end
        if (state_reg == S_DIV_Z && div_rsp.done) begin
            cz_reg <= neg_z_reg ? -quo_signed : quo_signed;
        end
        // Index of the centre tile, low index bits only
        if (state_reg == S_BASE) begin
            base_reg <= IDX_W'(cx_reg) + IDX_W'(cz_reg[IDX_W-1:0] * IDX_W'(w_sat));
        end
        if (load) begin
            pt_reg <= pt_reg + 1'b1;
            if (pt_reg == 3'd7) begin
                tx_reg   <= tx_step;
                tz_reg   <= tz_step;
                d_reg    <= d_step;
                step_reg <= step_reg + 1'b1;
            end
        end
    end

    // Output register
    logic                 m_tvalid_reg;
    logic [M_TDATA_W-1:0] m_tdata_reg;
    logic                 m_tuser_reg, m_tlast_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_tvalid_reg <= 1'b0;
        end else if (load) begin
            m_tvalid_reg <= 1'b1;
        end else if (m_tready) begin
            m_tvalid_reg <= 1'b0;
        end
        if (load) begin
            m_tdata_reg <= {2'b00, (in_grid ? tile_idx : IDX_W'(0)), off_z, off_x};
            m_tuser_reg <= in_grid;
            m_tlast_reg <= last_pt;
        end
    end

    assign m_tvalid = m_tvalid_reg;
    assign m_tdata  = m_tdata_reg;
    assign m_tuser  = m_tuser_reg;
    assign m_tlast  = m_tlast_reg;

`ifndef ASSERT_OFF
    // A point outside the grid carries a zero index
    a_outside_zero: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && !m_tuser |-> m_tdata[29:10] == '0)
        else $error("outside point with non-zero tile index");

    // Offsets never leave the largest ring
    a_offset_bound: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid |-> (signed'(m_tdata[4:0]) <= MAX_RADIUS)
                  && (signed'(m_tdata[4:0]) >= -MAX_RADIUS)
                  && (signed'(m_tdata[9:5]) <= MAX_RADIUS)
                  && (signed'(m_tdata[9:5]) >= -MAX_RADIUS))
        else $error("circle offset out of range");

    // The final point of a ring frees the input side
    a_last_idle: assert property (@(posedge aclk) disable iff (!aresetn)
        load && last_pt |=> s_tready && m_tvalid && m_tlast)
        else $error("walk did not finish on the last point");

    // No new divide is started while the walk emits
    a_no_div_in_emit: assert property (@(posedge aclk) disable iff (!aresetn)
        state_reg == S_EMIT |-> !div_req.start)
        else $error("divider started during emission");
`endif

endmodule

FILE: rtl/crts_div.sv
// ----------------------------------------------------------------------------
// crts_div
// Restoring unsigned divider, one quotient bit per cycle.
// ----------------------------------------------------------------------------
module crts_div (
    input  logic              aclk,
    input  logic              aresetn,
    input  crts_pkg::div_req_t req,
    output crts_pkg::div_rsp_t rsp
);
    import crts_pkg::*;

    localparam logic [DIV_CNT_W-1:0] LAST_STEP = DIV_CNT_W'(DIVIDEND_W - 1);

    logic                  busy_reg, busy_next;
    logic                  done_reg, done_next;
    logic [DIV_CNT_W-1:0]  count_reg, count_next;
    logic [DIVISOR_W-1:0]  rem_reg, rem_next;
    logic [DIVIDEND_W-1:0] quo_reg, quo_next;
    logic [DIVISOR_W-1:0]  divisor_reg, divisor_next;
    logic [DIVISOR_W:0]    trial;
    logic                  fits;

    // One trial subtraction per cycle
    assign trial = {rem_reg, quo_reg[DIVIDEND_W-1]};
    assign fits  = trial >= {1'b0, divisor_reg};

    always_comb begin
        busy_next    = busy_reg;
        done_next    = 1'b0;
        count_next   = count_reg;
        rem_next     = rem_reg;
        quo_next     = quo_reg;
        divisor_next = divisor_reg;
        if (req.start) begin
            busy_next    = 1'b1;
            count_next   = '0;
            rem_next     = '0;
            quo_next     = req.dividend;
            divisor_next = req.divisor;
        end else if (busy_reg) begin
            rem_next   = fits ? DIVISOR_W'(trial - {1'b0, divisor_reg})
                              : trial[DIVISOR_W-1:0];
            quo_next   = {quo_reg[DIVIDEND_W-2:0], fits};
            count_next = count_reg + 1'b1;
            if (count_reg == LAST_STEP) begin
                busy_next = 1'b0;
                done_next = 1'b1;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
        end else begin
            busy_reg <= busy_next;
            done_reg <= done_next;
        end
        count_reg   <= count_next;
        rem_reg     <= rem_next;
        quo_reg     <= quo_next;
        divisor_reg <= divisor_next;
    end

    assign rsp.done     = done_reg;
    assign rsp.quotient = quo_reg;

endmodule
